### hw/rtl/dos_pkg.sv
// Package: widths, codes and register indexes for the Duffing oscillator step block.
`default_nettype none
package dos_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned DtW = 17;
  localparam int unsigned ModeW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW = 96;
  localparam int unsigned OutDataW = 128;

  localparam logic [CfgIdxW-1:0] REG_DT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DAMP = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OMEGA = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BETA = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MODE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_X0 = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_V0 = 3'd6;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic signed [DataW-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] S32_MIN = 32'sh80000000;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return S32_MAX;
    if (v < -68'sd2147483648) return S32_MIN;
    return v[DataW-1:0];
  endfunction

  // v / 2^16 (or / 2^17 when half is set), rounded half away from zero, saturated
  function automatic logic signed [DataW-1:0] rnd_shr(input logic signed [67:0] v,
                                                      input logic half);
    logic [67:0] m, r;
    m = v < 0 ? -v : v;
    r = half ? (m + 68'd65536) >> 17 : (m + 68'd32768) >> 16;
    if (v < 0) return r > 68'd2147483648 ? S32_MIN : 32'(-r);
    return r > 68'd2147483647 ? S32_MAX : r[DataW-1:0];
  endfunction
endpackage
`default_nettype wire

### hw/rtl/dos_div.sv
// Shared multi-cycle signed divider: round half away from zero, saturate to 32 bits.
`default_nettype none
module dos_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [67:0] num,
  input  wire logic signed [67:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  localparam int unsigned W = 68;
  logic [W-1:0] nm, dm, rem, q;
  logic [6:0] cnt;
  logic busy, neg, nz, dz;
  logic [W:0] trial;
  logic [W-1:0] rem_sh;

  always_comb begin
    rem_sh = {rem[W-2:0], nm[W-1]};
    trial = {1'b0, rem_sh} - {1'b0, dm};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nm <= (num < 0 ? -num : num) + ((den < 0 ? -den : den) >> 1);
        dm <= den < 0 ? -den : den;
        neg <= (num < 0) != (den < 0);
        nz <= num != 0;
        dz <= den == 0;
        rem <= '0;
        q <= '0;
        cnt <= 7'(W);
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q <= {q[W-2:0], 1'b0};
        end
        nm <= {nm[W-2:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) busy <= 1'b0;
        if (cnt == 7'd1) done <= 1'b1;
      end
    end
  end

  logic [W-1:0] qf;
  assign qf = trial[W] ? {q[W-2:0], 1'b0} : {q[W-2:0], 1'b1};
  always_ff @(posedge clk) begin
    if (busy && cnt == 7'd1) begin
      if (dz) quo <= !nz ? 32'sd0 : (neg ? dos_pkg::S32_MIN : dos_pkg::S32_MAX);
      else if (neg) quo <= qf > 68'd2147483648 ? dos_pkg::S32_MIN : 32'(-qf);
      else quo <= qf > 68'd2147483647 ? dos_pkg::S32_MAX : qf[31:0];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/duffing_oscillator_step_top.sv
// Top level: Duffing oscillator central-difference step on one shared multiplier and divider.
// Step request: nine multiply operations, three divides and a square;
// m_tvalid rises from S_OUT after the square, and the next request is taken in the cycle after.
// Restart request: two multiplies, after which the block returns to idle for the next request.
// One request at a time; a held result delays the output register load and the return to idle.
// Synchronous reset restores register defaults and clears all oscillator state.
`default_nettype none
module duffing_oscillator_step_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,  // drive, external_f, drag_input
  input  wire logic         s_tuser,  // op
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata   // position, velocity, acceleration, position_squared, 0
);
  typedef logic signed [31:0] s32_t;
  typedef logic signed [33:0] m_t;
  typedef logic signed [67:0] w_t;
  localparam logic [4:0] S_IDLE = 5'd0, S_R1 = 5'd1, S_R2 = 5'd2, S_CT = 5'd3,
    S_FA = 5'd4, S_AL = 5'd5, S_FF = 5'd6, S_F3 = 5'd7, S_AF = 5'd8, S_BF = 5'd9,
    S_PP = 5'd10, S_SF = 5'd11, S_X = 5'd12, S_V = 5'd13, S_A = 5'd14, S_X2 = 5'd15,
    S_OUT = 5'd16, S_WAIT = 5'd17;
  logic [4:0] state;
  logic [16:0] dt;
  s32_t damp, omega, beta, x0, v0;
  logic [2:0] mode;
  s32_t prev, pprev, lvel, ssq;
  s32_t drive, drag, f, ctau, fa, alpha, t, f3, af, num_pp, x, v, accel;
  logic [30:0] x2;
  logic signed [33:0] force_w;
  w_t num_w;
  w_t dnum, dden;
  logic dstart, ddone;
  s32_t q;
  m_t ma, mb;
  w_t mp, mp_r;
  s32_t mq, r;
  logic pend, is_div, go;

  dos_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(q));

  assign cfg_ready = 1'b1;
  assign s_tready = state == S_IDLE;

  always_comb begin
    ma = '0; mb = '0;
    case (state)
      S_R1: begin ma = m_t'(v0); mb = m_t'(dt); end
      S_R2: begin ma = m_t'(dt); mb = m_t'(dt); end
      S_CT: begin ma = m_t'(dt); mb = m_t'(damp); end
      S_FA: begin ma = m_t'(drag); mb = m_t'(lvel); end
      S_AL: begin ma = m_t'(omega); mb = m_t'(omega); end
      S_FF: begin ma = m_t'(f); mb = m_t'(f); end
      S_F3: begin ma = m_t'(t); mb = m_t'(f); end
      S_AF: begin ma = m_t'(alpha); mb = m_t'(f); end
      S_BF: begin ma = m_t'(beta); mb = m_t'(f3); end
      S_PP: begin ma = m_t'(pprev); mb = m_t'(dos_pkg::sat32(68'sd65536 - ctau)); end
      S_SF: begin ma = m_t'(ssq); mb = force_w; end
      S_X2: begin ma = m_t'(x); mb = m_t'(x); end
      default: ;
    endcase
    mp = ma * mb;
  end

  always_comb begin
    mq = dos_pkg::rnd_shr(mp_r, state == S_CT);
    if (state == S_FA && !mode[1]) mq = drag;
    if (state == S_AL && mode[2]) mq = omega;
    is_div = state inside {S_X, S_V, S_A};
    r = is_div ? q : mq;
    go = pend && (!is_div || ddone);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0; dstart <= 1'b0; pend <= 1'b0;
      dt <= 17'd655; damp <= '0; omega <= 32'sd65536; beta <= '0; mode <= '0;
      x0 <= '0; v0 <= '0; prev <= '0; pprev <= '0; lvel <= '0; ssq <= '0;
    end else begin
      dstart <= is_div && !pend;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dos_pkg::REG_DT: dt <= cfg_data[16:0];
          dos_pkg::REG_DAMP: damp <= cfg_data;
          dos_pkg::REG_OMEGA: omega <= cfg_data;
          dos_pkg::REG_BETA: beta <= cfg_data;
          dos_pkg::REG_MODE: mode <= cfg_data[2:0];
          dos_pkg::REG_X0: x0 <= cfg_data;
          dos_pkg::REG_V0: v0 <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata <= {1'b0, x2, accel, v, x};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_IDLE) begin
        if (s_tvalid) begin
          drive <= s_tdata[31:0]; drag <= s_tdata[95:64];
          f <= mode[0] ? s_tdata[63:32] : prev;
          state <= s_tuser == dos_pkg::OP_RESTART ? S_R1 : S_CT;
        end
      end else if (state == S_OUT) begin
        if (!m_tvalid || m_tready) state <= S_IDLE;
      end else if (!pend) begin
        pend <= 1'b1;
        mp_r <= mp;
        case (state)
          S_X: begin dnum <= num_w <<< 16; dden <= 68'sd65536 + ctau; end
          S_V: begin dnum <= (w_t'(x) - pprev) <<< 16; dden <= w_t'(dt) <<< 1; end
          S_A: begin dnum <= (w_t'(x) - (w_t'(prev) <<< 1) + pprev) <<< 16; dden <= ssq; end
          default: ;
        endcase
      end else if (go) begin
        pend <= 1'b0;
        case (state)
          S_R1: begin lvel <= v0; prev <= x0; pprev <= dos_pkg::sat32(w_t'(x0) - r);
            state <= S_R2; end
          S_R2: begin ssq <= r; state <= S_IDLE; end
          S_CT: begin ctau <= r; state <= S_FA; end
          S_FA: begin fa <= r; state <= S_AL; end
          S_AL: begin alpha <= r; state <= S_FF; end
          S_FF: begin t <= r; state <= S_F3; end
          S_F3: begin f3 <= r; state <= S_AF; end
          S_AF: begin af <= r; state <= S_BF; end
          S_BF: begin force_w <= 34'(dos_pkg::sat32(w_t'(drive) - fa - af - r));
            state <= S_PP; end
          S_PP: begin num_pp <= r; state <= S_SF; end
          S_SF: begin
            num_w <= (w_t'(prev) <<< 1) - w_t'(num_pp) + w_t'(r);
            state <= S_X;
          end
          S_X: begin x <= r; state <= S_V; end
          S_V: begin v <= r; state <= S_A; end
          S_A: begin accel <= r; state <= S_X2; end
          S_X2: begin
            x2 <= r < 0 ? 31'd0 : r[30:0];
            pprev <= prev; prev <= x; lvel <= v; state <= S_OUT;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

### sim/duffing_oscillator_step_top_tb.sv
// Testbench for the Duffing oscillator step block: random and directed requests checked against a predictor.
`default_nettype none
module duffing_oscillator_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QONE = 65536;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int SETTLE = 400;
  localparam longint LIMIT = 64'd40000000;

  typedef struct packed {
    logic op;
    logic signed [dos_pkg::DataW-1:0] drive;
    logic signed [dos_pkg::DataW-1:0] ext_f;
    logic signed [dos_pkg::DataW-1:0] drag;
  } req_t;

  typedef struct packed {
    logic signed [dos_pkg::DataW-1:0] pos;
    logic signed [dos_pkg::DataW-1:0] vel;
    logic signed [dos_pkg::DataW-1:0] acc;
    logic [30:0] pos_sq;
  } state_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;  // drive, external_f, drag_input
  logic s_tuser = 1'b0;       // op
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;      // position, velocity, acceleration, position_squared

  duffing_oscillator_step_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow registers and oscillator state
  logic [dos_pkg::DtW-1:0] sh_dt = 17'd655;
  logic signed [dos_pkg::DataW-1:0] sh_damp = 0, sh_omega = 32'sd65536, sh_beta = 0;
  logic [dos_pkg::ModeW-1:0] sh_mode = 0;
  logic signed [dos_pkg::DataW-1:0] sh_x0 = 0, sh_v0 = 0;
  logic signed [dos_pkg::DataW-1:0] st_prev = 0, st_prev2 = 0, st_vel = 0, st_h2 = 0;

  req_t pending_reqs[$];
  state_out_t expected_states[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;
  int errors = 0;
  longint cycles = 0;

  function automatic longint round_div(longint n, longint d);
    logic neg;
    longint unsigned nm, dm, q;
    neg = (n < 0) != (d < 0);
    nm = n < 0 ? -n : n;
    dm = d < 0 ? -d : d;
    if (dm == 0) return nm == 0 ? 0 : (n < 0 ? SMIN : SMAX);
    q = (nm + dm / 2) / dm;
    if (neg) return q > 64'd2147483648 ? SMIN : -longint'(q);
    return q > 64'd2147483647 ? SMAX : longint'(q);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return round_div(a * b, QONE);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    return round_div(n * QONE, d);
  endfunction

  function automatic longint clamp32(longint v);
    return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
  endfunction

  // advances the oscillator state by one request; returns 1 when a result is due
  function automatic bit advance_oscillator(req_t r, output state_out_t o);
    longint dt, f, ctau, fa, alpha, f3, force_v, num, x, v, a, x2;
    dt = longint'(sh_dt);
    if (r.op == dos_pkg::OP_RESTART) begin
      st_vel = sh_v0;
      st_prev = sh_x0;
      st_prev2 = 32'(clamp32(longint'(sh_x0) - fx_mul(sh_v0, dt)));
      st_h2 = 32'(fx_mul(dt, dt));
      return 0;
    end
    f = sh_mode[0] ? longint'(r.ext_f) : longint'(st_prev);
    ctau = round_div(dt * longint'(sh_damp), 2 * QONE);
    fa = sh_mode[1] ? fx_mul(r.drag, st_vel) : longint'(r.drag);
    alpha = sh_mode[2] ? longint'(sh_omega) : fx_mul(sh_omega, sh_omega);
    f3 = fx_mul(fx_mul(f, f), f);
    force_v = clamp32(longint'(r.drive) - fa - fx_mul(alpha, f) - fx_mul(sh_beta, f3));
    num = 2 * longint'(st_prev) - fx_mul(st_prev2, clamp32(QONE - ctau))
        + fx_mul(st_h2, force_v);
    x = fx_div(num, QONE + ctau);
    v = fx_div(x - longint'(st_prev2), 2 * dt);
    a = fx_div(x - 2 * longint'(st_prev) + longint'(st_prev2), st_h2);
    x2 = fx_mul(x, x);
    if (x2 < 0) x2 = 0;
    st_prev2 = st_prev;
    st_prev = 32'(x);
    st_vel = 32'(v);
    o.pos = 32'(x);
    o.vel = 32'(v);
    o.acc = 32'(a);
    o.pos_sq = x2[30:0];
    return 1;
  endfunction

  // request driver
  always @(posedge clk) begin
    state_out_t o;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (advance_oscillator({s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]}, o))
          expected_states.push_back(o);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_t r;
          r = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= r.op;
          s_tdata <= {r.drag, r.ext_f, r.drive};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_start) hold_left <= 8000;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    state_out_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[126:96]};
        if (expected_states.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = expected_states.pop_front();
          if (got.pos !== want.pos || got.vel !== want.vel || got.acc !== want.acc
              || got.pos_sq !== want.pos_sq || m_tdata[127] !== 1'b0) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp x=%h v=%h a=%h x2=%h got x=%h v=%h a=%h x2=%h",
                       want.pos, want.vel, want.acc, want.pos_sq,
                       got.pos, got.vel, got.acc, got.pos_sq);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      dos_pkg::REG_DT: sh_dt = val[dos_pkg::DtW-1:0];
      dos_pkg::REG_DAMP: sh_damp = val;
      dos_pkg::REG_OMEGA: sh_omega = val;
      dos_pkg::REG_BETA: sh_beta = val;
      dos_pkg::REG_MODE: sh_mode = val[dos_pkg::ModeW-1:0];
      dos_pkg::REG_X0: sh_x0 = val;
      dos_pkg::REG_V0: sh_v0 = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (pending_reqs.size() == 0 && !s_tvalid && expected_states.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return dos_pkg::S32_MAX;
      1: return dos_pkg::S32_MIN;
      2, 3: return $urandom;
      default: return $urandom_range(524288) - 262144;
    endcase
  endfunction

  function automatic logic [31:0] small_value(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic queue_req(logic op, logic [31:0] u, logic [31:0] fe, logic [31:0] fd);
    req_t r;
    r.op = op;
    r.drive = u;
    r.ext_f = fe;
    r.drag = fd;
    pending_reqs.push_back(r);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: step before any restart, then extremes
    queue_req(dos_pkg::OP_STEP, 32'h0001_0000, 0, 0);
    queue_req(dos_pkg::OP_RESTART, 0, 0, 0);
    queue_req(dos_pkg::OP_STEP, dos_pkg::S32_MAX, dos_pkg::S32_MAX, dos_pkg::S32_MAX);
    queue_req(dos_pkg::OP_STEP, dos_pkg::S32_MIN, dos_pkg::S32_MIN, dos_pkg::S32_MIN);
    queue_req(dos_pkg::OP_STEP, 0, 0, 0);
    queue_req(dos_pkg::OP_STEP, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
    wait_drained();
    write_reg(dos_pkg::REG_DT, 32'd65536);
    write_reg(dos_pkg::REG_DAMP, -32'sd131072);  // 1 + ctau = 0
    write_reg(dos_pkg::REG_MODE, 3'd7);
    write_reg(dos_pkg::REG_X0, 32'h0002_0000);
    write_reg(dos_pkg::REG_V0, 32'hffff_0000);
    write_reg(dos_pkg::REG_OMEGA, dos_pkg::S32_MAX);
    write_reg(dos_pkg::REG_BETA, dos_pkg::S32_MIN);
    queue_req(dos_pkg::OP_RESTART, 0, 0, 0);
    queue_req(dos_pkg::OP_STEP, 32'h0000_1000, dos_pkg::S32_MAX, dos_pkg::S32_MIN);
    queue_req(dos_pkg::OP_STEP, dos_pkg::S32_MIN, dos_pkg::S32_MIN, dos_pkg::S32_MAX);
    wait_drained();
    write_reg(dos_pkg::REG_DT, 32'd0);
    write_reg(dos_pkg::REG_DAMP, 32'd0);
    write_reg(dos_pkg::REG_MODE, 3'd2);
    queue_req(dos_pkg::OP_RESTART, 0, 0, 0);
    queue_req(dos_pkg::OP_STEP, 32'h0001_0000, 0, 32'h0000_8000);
    queue_req(dos_pkg::OP_STEP, dos_pkg::S32_MAX, 0, dos_pkg::S32_MAX);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 74; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 74; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      case (p)
        0: write_reg(dos_pkg::REG_DT, 32'd655);
        1: write_reg(dos_pkg::REG_DT, 32'd65536);
        2: write_reg(dos_pkg::REG_DT, 32'd1);
        3: write_reg(dos_pkg::REG_DT, 32'd0);
        default: write_reg(dos_pkg::REG_DT, $urandom_range(8192, 64));
      endcase
      case (p)
        3: write_reg(dos_pkg::REG_DAMP, dos_pkg::S32_MAX);
        4: write_reg(dos_pkg::REG_DAMP, dos_pkg::S32_MIN);
        default: write_reg(dos_pkg::REG_DAMP, small_value(40000));
      endcase
      write_reg(dos_pkg::REG_OMEGA, p == 5 ? dos_pkg::S32_MIN : small_value(200000));
      write_reg(dos_pkg::REG_BETA, p == 6 ? dos_pkg::S32_MAX : small_value(30000));
      write_reg(dos_pkg::REG_MODE, p % 8);
      write_reg(dos_pkg::REG_X0, p == 7 ? $urandom : small_value(196608));
      write_reg(dos_pkg::REG_V0, small_value(196608));
      queue_req(dos_pkg::OP_RESTART, 0, 0, 0);
      for (int i = 0; i < 78; i++) begin
        if ($urandom_range(99) < 8)
          queue_req(dos_pkg::OP_RESTART, $urandom, $urandom, $urandom);
        else if ($urandom_range(99) < 80)
          queue_req(dos_pkg::OP_STEP, small_value(131072), small_value(196608),
                    small_value(32768));
        else queue_req(dos_pkg::OP_STEP, rand_value(), rand_value(), rand_value());
      end
      if (p == 2) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_drained();
    end

    errors += expected_states.size();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
